/* rtl/abs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and codes for the alternating-bit sender.
// ----------------------------------------------------------------------------
package abs_pkg;

    localparam int unsigned SUM_W    = 14;
    localparam int unsigned ACKSUM_W = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd15;

    typedef enum logic [1:0] {
        K_MSG_BYTE = 2'd0,
        K_ACK_BYTE = 2'd1,
        K_ACK_HDR  = 2'd2,
        K_EXPIRY   = 2'd3
    } t_in_kind;

    typedef enum logic [2:0] {
        O_PAYLOAD     = 3'd0,
        O_HEADER      = 3'd1,
        O_START_TIMER = 3'd2,
        O_STOP_TIMER  = 3'd3,
        O_MSG_DROPPED = 3'd4,
        O_ACK_DISCARD = 3'd5,
        O_EXPIRY_IGN  = 3'd6
    } t_out_kind;

    typedef enum logic [1:0] {
        R_NOT_WAITING = 2'd0,
        R_CORRUPTED   = 2'd1,
        R_WRONG_ACK   = 2'd2
    } t_reason;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SEND,
        S_HDR,
        S_TMR,
        S_ONE
    } t_state;

    typedef struct packed {
        logic      acc;
        logic      idx_clr;
        logic      idx_inc;
        logic      push;
        t_out_kind okind;
        t_reason   reason;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        logic waiting;
        logic msg_last;
        logic ack_sum_ok;
        logic ack_num_ok;
        logic idx_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/abs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 20,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/abs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_ctrl
// Sequencer: dispatches input words and steps out result words.
// ----------------------------------------------------------------------------
module abs_ctrl
    import abs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_kind,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state    r_state, n_state;
    t_out_kind r_one_kind, n_one_kind;
    t_reason   r_one_reason, n_one_reason;
    logic      acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_one_kind   <= n_one_kind;
        r_one_reason <= n_one_reason;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_one_kind   = r_one_kind;
        n_one_reason = r_one_reason;
        o_cmd        = '0;
        o_cmd.okind  = O_PAYLOAD;
        o_cmd.reason = R_NOT_WAITING;
        o_cmd.acc    = acc;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_one_reason = R_NOT_WAITING;
                    case (t_in_kind'(i_kind))
                        K_MSG_BYTE: begin
                            if (i_status.msg_last) begin
                                if (i_status.waiting) begin
                                    n_one_kind = O_MSG_DROPPED;
                                    n_state    = S_ONE;
                                end else begin
                                    n_state = S_PREP;
                                end
                            end
                        end
                        K_ACK_HDR: begin
                            n_state = S_ONE;
                            if (!i_status.waiting) begin
                                n_one_kind = O_ACK_DISCARD;
                            end else if (!i_status.ack_sum_ok) begin
                                n_one_kind   = O_ACK_DISCARD;
                                n_one_reason = R_CORRUPTED;
                            end else if (!i_status.ack_num_ok) begin
                                n_one_kind   = O_ACK_DISCARD;
                                n_one_reason = R_WRONG_ACK;
                            end else begin
                                n_one_kind = O_STOP_TIMER;
                            end
                        end
                        K_EXPIRY: begin
                            if (i_status.waiting) begin
                                n_state = S_PREP;
                            end else begin
                                n_one_kind = O_EXPIRY_IGN;
                                n_state    = S_ONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PREP: begin
                o_cmd.idx_clr = 1'b1;
                n_state       = S_SEND;
            end
            S_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.okind   = O_PAYLOAD;
                    if (i_status.idx_last) begin
                        n_state = S_HDR;
                    end
                end
            end
            S_HDR: begin
                if (i_status.out_free) begin
                    o_cmd.push  = 1'b1;
                    o_cmd.okind = O_HEADER;
                    n_state     = S_TMR;
                end
            end
            S_TMR: begin
                if (i_status.out_free) begin
                    o_cmd.push  = 1'b1;
                    o_cmd.okind = O_START_TIMER;
                    o_cmd.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ONE: begin
                if (i_status.out_free) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.okind  = r_one_kind;
                    o_cmd.reason = r_one_reason;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/abs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_dp
// Datapath: protocol state, sums, packet store and output register.
// ----------------------------------------------------------------------------
module abs_dp
    import abs_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = 20,
    localparam int unsigned AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_data_byte,
    input  logic signed [31:0]  i_ack_seqnum,
    input  logic signed [31:0]  i_ack_acknum,
    input  logic signed [31:0]  i_ack_checksum,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    output logic                o_cfg_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_out_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_out_seqnum,
    output logic                o_out_acknum,
    output logic [13:0]         o_out_checksum,
    output logic [15:0]         o_timer_period,
    output logic [1:0]          o_discard_reason,
    output logic                o_last
);

    localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_BYTES - 1);

    logic                r_waiting, n_waiting;
    logic                r_seq, n_seq;
    logic [AW-1:0]       r_msg_cnt, n_msg_cnt;
    logic [SUM_W-1:0]    r_msg_sum, n_msg_sum;
    logic [SUM_W-1:0]    r_stored, n_stored;
    logic [ACKSUM_W-1:0] r_ack_sum, n_ack_sum;
    logic [PERIOD_W-1:0] r_period;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_out_valid;
    logic [2:0]          r_out_kind;
    logic [7:0]          r_out_byte;
    logic                r_out_seq;
    logic [SUM_W-1:0]    r_out_csum;
    logic [PERIOD_W-1:0] r_out_period;
    logic [1:0]          r_out_reason;
    logic                r_out_last;

    logic [ACKSUM_W-1:0] expect_sum;
    logic [SUM_W-1:0]    sum_base;
    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;
    logic                is_msg, is_ack_byte, is_ack_hdr;

    assign is_msg      = i_cmd.acc && (t_in_kind'(i_kind) == K_MSG_BYTE);
    assign is_ack_byte = i_cmd.acc && (t_in_kind'(i_kind) == K_ACK_BYTE);
    assign is_ack_hdr  = i_cmd.acc && (t_in_kind'(i_kind) == K_ACK_HDR);

    assign expect_sum = i_ack_seqnum + i_ack_acknum + r_ack_sum;

    assign o_status.waiting    = r_waiting;
    assign o_status.msg_last   = (r_msg_cnt == LAST_IDX);
    assign o_status.ack_sum_ok = (i_ack_checksum == expect_sum);
    assign o_status.ack_num_ok = (i_ack_acknum == {31'd0, r_seq});
    assign o_status.idx_last   = (r_idx == LAST_IDX);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign ram_we    = is_msg && !r_waiting;
    assign ram_raddr = n_idx;

    abs_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_msg_cnt),
        .i_wdata (i_data_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_waiting = r_waiting;
        n_seq     = r_seq;
        n_msg_cnt = r_msg_cnt;
        n_msg_sum = r_msg_sum;
        n_stored  = r_stored;
        n_ack_sum = r_ack_sum;
        n_idx     = r_idx;
        sum_base  = (r_msg_cnt == '0) ? '0 : r_msg_sum;

        if (is_msg) begin
            n_msg_sum = sum_base;
            if (!r_waiting) begin
                n_msg_sum = sum_base + SUM_W'(i_data_byte);
            end
            if (o_status.msg_last) begin
                n_msg_cnt = '0;
                if (!r_waiting) begin
                    n_stored  = n_msg_sum + SUM_W'(r_seq);
                    n_waiting = 1'b1;
                end
            end else begin
                n_msg_cnt = r_msg_cnt + 1'b1;
            end
        end
        if (is_ack_byte) begin
            n_ack_sum = r_ack_sum + ACKSUM_W'(i_data_byte);
        end
        if (is_ack_hdr) begin
            n_ack_sum = '0;
            if (r_waiting && o_status.ack_sum_ok && o_status.ack_num_ok) begin
                n_seq     = !r_seq;
                n_waiting = 1'b0;
            end
        end

        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc && !o_status.idx_last) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_seq       <= 1'b0;
            r_msg_cnt   <= '0;
            r_msg_sum   <= '0;
            r_stored    <= '0;
            r_ack_sum   <= '0;
            r_period    <= RESET_PERIOD;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_waiting <= n_waiting;
            r_seq     <= n_seq;
            r_msg_cnt <= n_msg_cnt;
            r_msg_sum <= n_msg_sum;
            r_stored  <= n_stored;
            r_ack_sum <= n_ack_sum;
            r_idx     <= n_idx;
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_kind   <= i_cmd.okind;
            r_out_byte   <= (i_cmd.okind == O_PAYLOAD) ? ram_rdata : 8'd0;
            r_out_seq    <= (i_cmd.okind == O_HEADER) ? r_seq : 1'b0;
            r_out_csum   <= (i_cmd.okind == O_HEADER) ? r_stored : '0;
            r_out_period <= (i_cmd.okind == O_START_TIMER) ? r_period : '0;
            r_out_reason <= i_cmd.reason;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out_kind;
    assign o_out_byte       = r_out_byte;
    assign o_out_seqnum     = r_out_seq;
    assign o_out_acknum     = 1'b0;
    assign o_out_checksum   = r_out_csum;
    assign o_timer_period   = r_out_period;
    assign o_discard_reason = r_out_reason;
    assign o_last           = r_out_last;

endmodule

/* rtl/alternating_bit_sender.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_bit_sender
// Stop-and-wait sender: stores a message, sends it with header and timer
// start, checks acks and resends on timer expiry.
// ----------------------------------------------------------------------------
// Message bytes and ack payload bytes are taken one per cycle; a result word
// appears in the output register the cycle after it is formed.
// A packet send or resend steps the sequencer through a store read prefetch, then
// payload words, header and timer start, one per cycle unless the output stalls.
// A single report goes out from S_ONE; input is held off while words go out.
// Synchronous active-low reset returns to idle, sequence bit 0, period 15.
module alternating_bit_sender
    import abs_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_data_byte,
    input  logic signed [31:0] i_ack_seqnum,
    input  logic signed [31:0] i_ack_acknum,
    input  logic signed [31:0] i_ack_checksum,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_out_kind,
    output logic [7:0]         o_out_byte,
    output logic               o_out_seqnum,
    output logic               o_out_acknum,
    output logic [13:0]        o_out_checksum,
    output logic [15:0]        o_timer_period,
    output logic [1:0]         o_discard_reason,
    output logic               o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    abs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    abs_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_ack_seqnum     (i_ack_seqnum),
        .i_ack_acknum     (i_ack_acknum),
        .i_ack_checksum   (i_ack_checksum),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_cfg_ready      (o_cfg_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_out_seqnum     (o_out_seqnum),
        .o_out_acknum     (o_out_acknum),
        .o_out_checksum   (o_out_checksum),
        .o_timer_period   (o_timer_period),
        .o_discard_reason (o_discard_reason),
        .o_last           (o_last)
    );

    // a result word is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> status.out_free)
        else $error("result word overwritten");

    // no result word is formed while input is being taken
    a_idle_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.push)
        else $error("push while idle");

    // a good ack header ends the wait
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.acc && (t_in_kind'(i_kind) == K_ACK_HDR) && status.waiting
         && status.ack_sum_ok && status.ack_num_ok) |=> !status.waiting)
        else $error("valid ack did not clear wait");

    // the final word of a run is a timer start or a single report
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push && cmd.last) |-> (cmd.okind != O_PAYLOAD && cmd.okind != O_HEADER))
        else $error("bad last word");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alternating-bit sender. A behavioral copy of the
// sender follows every accepted input word and queues the words the block must
// send; each output word is checked field by field, in order. Directed items
// come first, then random messages, acks and expiries under several timer
// periods, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import abs_pkg::*;

    localparam int unsigned PAYLOAD       = 20;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef enum int unsigned {ACK_GOOD, ACK_CORRUPT, ACK_WRONG_NUM} t_ack_flavor;
    typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_BURSTY} t_rx_mode;

    typedef struct {
        t_out_kind             kind;
        logic [7:0]            data;
        logic                  seqnum;
        logic                  acknum;
        logic [SUM_W-1:0]      checksum;
        logic [PERIOD_W-1:0]   period;
        t_reason               reason;
        logic                  last;
    } t_word;

    class sender_board;
        t_word               pending_words[$];
        bit                  waiting;
        bit                  seq_bit;
        bit [7:0]            packet_bytes[PAYLOAD];
        int unsigned         msg_count;
        bit [SUM_W-1:0]      msg_sum;
        bit [SUM_W-1:0]      packet_csum;
        bit [31:0]           ack_sum;
        bit [PERIOD_W-1:0]   period;
        int                  errors;

        function new();
            period      = RESET_PERIOD;
            waiting     = 1'b0;
            seq_bit     = 1'b0;
            msg_count   = 0;
            msg_sum     = '0;
            packet_csum = '0;
            ack_sum     = '0;
            errors      = 0;
            foreach (packet_bytes[i]) packet_bytes[i] = '0;
        endfunction

        function void add_word(t_out_kind kind, logic [7:0] data, logic seqnum,
                               logic [SUM_W-1:0] csum, logic [PERIOD_W-1:0] per,
                               t_reason reason);
            t_word w;
            w.kind     = kind;
            w.data     = data;
            w.seqnum   = seqnum;
            w.acknum   = 1'b0;
            w.checksum = csum;
            w.period   = per;
            w.reason   = reason;
            w.last     = 1'b0;
            pending_words.push_back(w);
        endfunction

        function void add_packet();
            for (int i = 0; i < PAYLOAD; i++) begin
                add_word(O_PAYLOAD, packet_bytes[i], 1'b0, '0, '0, R_NOT_WAITING);
            end
            add_word(O_HEADER, '0, seq_bit, packet_csum, '0, R_NOT_WAITING);
            add_word(O_START_TIMER, '0, 1'b0, '0, period, R_NOT_WAITING);
        endfunction

        function void note_input(t_in_kind kind, bit [7:0] data, bit [31:0] a_seq,
                                 bit [31:0] a_ack, bit [31:0] a_csum);
            int unsigned before_cnt;
            bit [31:0]   sum_ok;
            t_word       w;
            before_cnt = pending_words.size();
            case (kind)
                K_MSG_BYTE: begin
                    if (msg_count == 0) msg_sum = '0;
                    // bytes that arrive while busy are counted but not stored
                    if (!waiting) begin
                        packet_bytes[msg_count] = data;
                        msg_sum = msg_sum + SUM_W'(data);
                    end
                    if (msg_count + 1 >= PAYLOAD) begin
                        msg_count = 0;
                        if (waiting) begin
                            add_word(O_MSG_DROPPED, '0, 1'b0, '0, '0, R_NOT_WAITING);
                        end else begin
                            packet_csum = msg_sum + SUM_W'(seq_bit);
                            waiting = 1'b1;
                            add_packet();
                        end
                    end else begin
                        msg_count++;
                    end
                end
                K_ACK_BYTE: begin
                    ack_sum = ack_sum + 32'(data);
                end
                K_ACK_HDR: begin
                    sum_ok  = a_seq + a_ack + ack_sum;
                    ack_sum = '0;
                    if (!waiting) begin
                        add_word(O_ACK_DISCARD, '0, 1'b0, '0, '0, R_NOT_WAITING);
                    end else if (a_csum != sum_ok) begin
                        add_word(O_ACK_DISCARD, '0, 1'b0, '0, '0, R_CORRUPTED);
                    end else if (a_ack != {31'b0, seq_bit}) begin
                        add_word(O_ACK_DISCARD, '0, 1'b0, '0, '0, R_WRONG_ACK);
                    end else begin
                        add_word(O_STOP_TIMER, '0, 1'b0, '0, '0, R_NOT_WAITING);
                        seq_bit = ~seq_bit;
                        waiting = 1'b0;
                    end
                end
                default: begin
                    if (!waiting) add_word(O_EXPIRY_IGN, '0, 1'b0, '0, '0, R_NOT_WAITING);
                    else add_packet();
                end
            endcase
            if (pending_words.size() > before_cnt) begin
                w = pending_words.pop_back();
                w.last = 1'b1;
                pending_words.push_back(w);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_word got);
            t_word want;
            if (pending_words.size() == 0) begin
                $error("unexpected word, out_kind %0d", got.kind);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("out_kind", want.kind, got.kind);
            compare_field("out_byte", want.data, got.data);
            compare_field("out_seqnum", want.seqnum, got.seqnum);
            compare_field("out_acknum", want.acknum, got.acknum);
            compare_field("out_checksum", want.checksum, got.checksum);
            compare_field("timer_period", want.period, got.period);
            compare_field("discard_reason", want.reason, got.reason);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_kind         = K_MSG_BYTE;
    logic [7:0]         i_data_byte    = '0;
    logic signed [31:0] i_ack_seqnum   = '0;
    logic signed [31:0] i_ack_acknum   = '0;
    logic signed [31:0] i_ack_checksum = '0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data     = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [2:0]         o_out_kind;
    logic [7:0]         o_out_byte;
    logic               o_out_seqnum;
    logic               o_out_acknum;
    logic [13:0]        o_out_checksum;
    logic [15:0]        o_timer_period;
    logic [1:0]         o_discard_reason;
    logic               o_last;

    sender_board  sender;
    int unsigned  burst_left  = 0;
    int unsigned  items_sent  = 0;
    int unsigned  cycle_count = 0;
    t_rx_mode     rx_mode     = RX_OPEN;
    int unsigned  rx_left     = 0;
    int unsigned  rx_hold     = 0;
    bit           rx_stall    = 1'b0;

    alternating_bit_sender #(
        .PAYLOAD_BYTES(PAYLOAD)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_ack_seqnum     (i_ack_seqnum),
        .i_ack_acknum     (i_ack_acknum),
        .i_ack_checksum   (i_ack_checksum),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_out_seqnum     (o_out_seqnum),
        .o_out_acknum     (o_out_acknum),
        .o_out_checksum   (o_out_checksum),
        .o_timer_period   (o_timer_period),
        .o_discard_reason (o_discard_reason),
        .o_last           (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output stalls: open, random, patterned or bursty, picked anew at random
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    i_out_ready <= 1'b1;
            RX_RANDOM:  i_out_ready <= ($urandom_range(0, 1) == 1);
            RX_PATTERN: i_out_ready <= (rx_left % 3 != 0);
            default: begin
                if (rx_hold == 0) begin
                    rx_hold  = $urandom_range(1, 12);
                    rx_stall = ~rx_stall;
                end
                rx_hold--;
                i_out_ready <= ~rx_stall;
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_word seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.kind     = t_out_kind'(o_out_kind);
            seen.data     = o_out_byte;
            seen.seqnum   = o_out_seqnum;
            seen.acknum   = o_out_acknum;
            seen.checksum = o_out_checksum;
            seen.period   = o_timer_period;
            seen.reason   = t_reason'(o_discard_reason);
            seen.last     = o_last;
            sender.check_word(seen);
        end
    end

    task automatic push_item(t_in_kind kind, logic [7:0] data, logic [31:0] a_seq,
                             logic [31:0] a_ack, logic [31:0] a_csum);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 20);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_data_byte    <= data;
        i_ack_seqnum   <= a_seq;
        i_ack_acknum   <= a_ack;
        i_ack_checksum <= a_csum;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sender.note_input(kind, data, a_seq, a_ack, a_csum);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_bytes(int unsigned n);
        repeat (n) push_item(K_MSG_BYTE, 8'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic send_noise();
        push_item(t_in_kind'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
                  $urandom);
    endtask

    task automatic drive_ack(t_ack_flavor flavor);
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] csum;
        repeat ($urandom_range(0, 4)) begin
            push_item(K_ACK_BYTE, 8'($urandom), $urandom, $urandom, $urandom);
        end
        seq = $urandom;
        case (flavor)
            ACK_GOOD: begin
                ack  = {31'b0, sender.seq_bit};
                csum = seq + ack + sender.ack_sum;
            end
            ACK_CORRUPT: begin
                ack  = ($urandom_range(0, 1) == 1) ? {31'b0, sender.seq_bit} : $urandom;
                csum = seq + ack + sender.ack_sum + ($urandom | 32'd1);
            end
            default: begin
                ack = $urandom;
                if (ack == {31'b0, sender.seq_bit}) ack = ack ^ 32'd2;
                csum = seq + ack + sender.ack_sum;
            end
        endcase
        push_item(K_ACK_HDR, 8'($urandom), seq, ack, csum);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sender.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(logic [15:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sender.period = value;
    endtask

    task automatic random_phase(int unsigned min_items);
        int unsigned start_count;
        int unsigned r;
        int unsigned pick;
        start_count = items_sent;
        while (items_sent - start_count < min_items) begin
            r = $urandom_range(0, 99);
            if (!sender.waiting) begin
                if (r < 65) send_bytes(PAYLOAD - sender.msg_count);
                else if (r < 80) send_bytes($urandom_range(1, PAYLOAD - 1));
                else send_noise();
            end else if (r < 25) begin
                push_item(K_EXPIRY, 8'($urandom), $urandom, $urandom, $urandom);
            end else if (r < 65) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) drive_ack(ACK_GOOD);
                else if (pick < 8) drive_ack(ACK_CORRUPT);
                else drive_ack(ACK_WRONG_NUM);
            end else if (r < 75) begin
                send_bytes(PAYLOAD - sender.msg_count);
            end else if (r < 90 && sender.msg_count < PAYLOAD - 2) begin
                // message that straddles a good ack
                send_bytes($urandom_range(1, PAYLOAD - 2 - sender.msg_count));
                drive_ack(ACK_GOOD);
                send_bytes(PAYLOAD - sender.msg_count);
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        sender = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle: expiry is ignored and ack header is discarded
        push_item(K_EXPIRY, 8'h00, 32'h0, 32'h0, 32'h0);
        push_item(K_ACK_BYTE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(K_ACK_HDR, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        for (int i = 0; i < PAYLOAD; i++) begin
            push_item(K_MSG_BYTE, (i == PAYLOAD - 1) ? 8'hA5 : ((i % 2 == 0) ? 8'hFF : 8'h00),
                      32'h0, 32'h0, 32'h0);
        end
        push_item(K_EXPIRY, 8'hFF, 32'h0, 32'h0, 32'h0);
        push_item(K_ACK_HDR, 8'h00, 32'h7FFF_FFFF, 32'h0, 32'h1234_5678);
        push_item(K_ACK_HDR, 8'h00, 32'hFFFF_FFFF, 32'h1, 32'h0);
        push_item(K_ACK_BYTE, 8'hFF, 32'h0, 32'h0, 32'h0);
        push_item(K_ACK_HDR, 8'h00, 32'hFFFF_FFFF, 32'h0, 32'h0000_00FE);

        write_period(16'hFFFF);
        random_phase(20);
        write_period(16'd1);
        random_phase(20);
        write_period(16'($urandom_range(2, 65534)));
        random_phase(20);
        drain();

        if (sender.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
